>>> design/jesl_pkg.sv
// ----------------------------------------------------------------------------
// jesl_pkg: shared types and constants of the JPEG Exif segment locator
// Holds the result status codes, the scan sequencer states, the offsets
// within a segment and the byte constants of the JPEG and Exif formats.
// ----------------------------------------------------------------------------
package jesl_pkg;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_EXIF_FOUND  = 3'd0,
      ST_NO_EXIF     = 3'd1,
      ST_NOT_JPEG    = 3'd2,
      ST_TRUNCATED   = 3'd3,
      ST_SEG_OVERRUN = 3'd4,
      ST_IFD_BAD     = 3'd5,
      ST_TIFF_CUT    = 3'd6
   } status_type;

   // Scan sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_MARK,
      S_HEAD,
      S_SEGCHK,
      S_SIG,
      S_SIGEND,
      S_TIFF,
      S_FINAL,
      S_RESULT
   } scan_state_type;

   // Byte history: the last WIN_DEPTH bytes are visible, kept in a ring.
   localparam int WIN_DEPTH  = 18;
   localparam int RING_DEPTH = 32;
   localparam int RING_BITS  = 5;
   localparam int OFF_BITS   = 5;

   // Byte offsets from the marker position.
   localparam logic [OFF_BITS-1:0] OFF_MARK_LO   = 5'd1;
   localparam logic [OFF_BITS-1:0] OFF_LEN_HI    = 5'd2;
   localparam logic [OFF_BITS-1:0] OFF_LEN_LO    = 5'd3;
   localparam logic [OFF_BITS-1:0] OFF_SIG_FIRST = 5'd4;
   localparam logic [OFF_BITS-1:0] OFF_SIG_LAST  = 5'd9;
   localparam logic [OFF_BITS-1:0] OFF_TIFF      = 5'd10;
   localparam logic [OFF_BITS-1:0] OFF_TIFF_LAST = 5'd17;

   // Format constants.
   localparam logic [7:0]  MARKER_PREFIX = 8'hFF;
   localparam logic [7:0]  SOI_SECOND    = 8'hD8;
   localparam logic [7:0]  APP1_CODE     = 8'hE1;
   localparam logic [15:0] ORDER_INTEL   = 16'h4949;

   // Result stream layout.
   localparam int RSP_DATA_BITS = 88;

   // Exif signature "Exif" followed by two zero bytes.
   function automatic logic [7:0] exif_sig_byte(input logic [2:0] sel);
      logic [7:0] val;
      case (sel)
         3'd0:    val = 8'h45;
         3'd1:    val = 8'h78;
         3'd2:    val = 8'h69;
         3'd3:    val = 8'h66;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

>>> design/jpeg_exif_segment_locator_core.sv
// ----------------------------------------------------------------------------
// jpeg_exif_segment_locator_core: finds the Exif APP1 segment of a JPEG file
// Takes the file one byte per request, checks the start-of-image marker, walks
// the marker segments and reports where the TIFF header of the Exif segment
// starts, its byte order and its first IFD offset, or why none was found.
// ----------------------------------------------------------------------------
// Write the file length to the csr port before the first byte, then stream the
// file with req_tuser set on byte 0. The length register is taken only while
// the core is idle and no byte request is offered. At most one response comes
// per file; bytes after it are dropped until req_tuser is set again. Each byte
// request enters in the idle state; every scan position then visited gets a
// bound check, then a fetch; a marker header, a signature compare and a TIFF
// header read add further fetch steps. A plain byte thus goes through entry,
// bound check and fetch of its own position, and the bound check of the next
// position, which then waits for its byte. This pace is set by the byte history
// buffer, a RAM of the last bytes that the sequencer reads one byte per cycle.
// The block does not take a request while it scans or while a response waits
// to be taken.
module jpeg_exif_segment_locator_core
   import jesl_pkg::*;
#(
   parameter int POS_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   // Configuration: file length in bytes.
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [31:0]              csr_data,
   // Byte requests.
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // [7:0] data_byte
   input  logic                     req_tuser,   // [0] first_byte
   // Responses.
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata    // [2:0] status, [3] little_endian,
                                                 // [35:4] tiff_start,
                                                 // [67:36] ifd_offset,
                                                 // [83:68] segment_length, zero pad
);

   localparam int CW = ((POS_BITS > 32) ? POS_BITS : 32) + 2;

   scan_state_type        state_ff, state_in;
   logic [POS_BITS-1:0]   count_ff, count_in;
   logic [POS_BITS-1:0]   idx_ff, idx_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic                  fin_ff, fin_in;
   logic [31:0]           flen_ff;
   logic [OFF_BITS-1:0]   off_ff, rd_off;
   logic [7:0]            mark_lo_ff, mark_lo_in;
   logic [15:0]           seg_ff, seg_in;
   logic                  match_ff, match_in;
   logic                  hit_ff;
   logic [7:0]            tiff_ff [8];
   logic                  tiff_we;

   status_type            status_ff;
   logic                  le_ff;
   logic [31:0]           tstart_ff;
   logic [31:0]           ifd_ff;
   logic [15:0]           seglen_ff;
   logic                  emit_en;
   status_type            emit_code;

   logic                  req_take, start_clear, fin_base, take_live;
   logic [POS_BITS-1:0]   cnt_base, pos_base;
   logic [7:0]            byte_in, ram_rdata, rd_byte;
   logic                  first_bad, second_bad;
   logic [CW-1:0]         p_x, len_x, idx_x, cnt_x, seg_x, q_x, skip_x, tstart_x;
   logic                  rd_hit;
   logic                  c_end, c_trunc, c_wait0, c_ff, c_wait3;
   logic                  c_overrun, c_app1, c_wait9, c_cut, c_wait17;
   logic                  order_le, c_ifd_bad;
   logic [31:0]           ifd_val;

   // Configuration is taken only while the scan is paused and no byte waits.
   assign csr_ready = (state_ff == S_IDLE) && !req_tvalid;

   always_ff @(posedge clock) begin
      if (reset) begin
         flen_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         flen_ff <= csr_data;
      end
   end

   // Request decode: a start flag restarts the scan before the byte is used.
   assign req_tready  = (state_ff == S_IDLE);
   assign req_take    = req_tvalid & req_tready;
   assign start_clear = req_tuser;
   assign byte_in     = req_tdata;
   assign cnt_base    = start_clear ? '0 : count_ff;
   assign pos_base    = start_clear ? POS_BITS'(2) : pos_ff;
   assign fin_base    = start_clear ? 1'b0 : fin_ff;
   assign take_live   = req_take & ~fin_base;
   assign first_bad   = (cnt_base == '0) &&
                        ((flen_ff < 32'd2) || (byte_in != MARKER_PREFIX));
   assign second_bad  = (cnt_base == POS_BITS'(1)) && (byte_in != SOI_SECOND);

   // Positions widened so that sums and compares never wrap.
   assign p_x    = CW'(pos_ff);
   assign len_x  = CW'(flen_ff);
   assign idx_x  = CW'(idx_ff);
   assign cnt_x  = CW'(count_ff);
   assign seg_x  = CW'(seg_ff);
   assign skip_x = p_x + CW'(2) + seg_x;
   assign tstart_x = p_x + CW'(OFF_TIFF);

   // Byte history read address: marker position plus the byte offset.
   always_comb begin
      case (state_ff)
         S_CHECK:  rd_off = '0;
         S_MARK:   rd_off = OFF_MARK_LO;
         S_SEGCHK: rd_off = OFF_SIG_FIRST;
         S_SIGEND: rd_off = OFF_TIFF;
         S_HEAD:   rd_off = off_ff + OFF_BITS'(1);
         S_SIG:    rd_off = off_ff + OFF_BITS'(1);
         S_TIFF:   rd_off = off_ff + OFF_BITS'(1);
         default:  rd_off = '0;
      endcase
   end

   assign q_x    = p_x + CW'(rd_off);
   assign rd_hit = (q_x < cnt_x) && ((cnt_x - q_x) <= CW'(WIN_DEPTH));

   jesl_ram #(
      .WIDTH (8),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (take_live),
      .wr_addr (cnt_base[RING_BITS-1:0]),
      .wr_data (byte_in),
      .rd_addr (q_x[RING_BITS-1:0]),
      .rd_data (ram_rdata)
   );

   // Bytes outside the visible history read as zero.
   assign rd_byte = hit_ff ? ram_rdata : 8'h00;

   // Bound and availability checks at the current scan position.
   assign c_end     = p_x >= len_x;
   assign c_trunc   = (p_x + CW'(4)) > len_x;
   assign c_wait0   = p_x > idx_x;
   assign c_ff      = rd_byte == MARKER_PREFIX;
   assign c_wait3   = (p_x + CW'(3)) > idx_x;
   assign c_overrun = skip_x > len_x;
   assign c_app1    = (mark_lo_ff == APP1_CODE) && ((p_x + CW'(OFF_TIFF)) <= len_x);
   assign c_wait9   = (p_x + CW'(OFF_SIG_LAST)) > idx_x;
   assign c_cut     = (p_x + CW'(18)) > len_x;
   assign c_wait17  = (p_x + CW'(OFF_TIFF_LAST)) > idx_x;

   // TIFF header decode.
   assign order_le  = {tiff_ff[0], tiff_ff[1]} == ORDER_INTEL;
   assign ifd_val   = order_le ? {tiff_ff[7], tiff_ff[6], tiff_ff[5], tiff_ff[4]}
                               : {tiff_ff[4], tiff_ff[5], tiff_ff[6], tiff_ff[7]};
   assign c_ifd_bad = (34'(ifd_val) + 34'(OFF_TIFF)) > 34'(seg_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (take_live) begin
               if (first_bad || second_bad) begin
                  state_in = S_RESULT;
               end else if (cnt_base != '0) begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (c_end || c_trunc) begin
               state_in = S_RESULT;
            end else if (c_wait0) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_MARK;
            end
         end
         S_MARK: begin
            if (!c_ff) begin
               state_in = S_CHECK;
            end else if (c_wait3) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            if (off_ff == OFF_LEN_LO) begin
               state_in = S_SEGCHK;
            end
         end
         S_SEGCHK: begin
            if (c_overrun) begin
               state_in = S_RESULT;
            end else if (c_app1) begin
               state_in = c_wait9 ? S_IDLE : S_SIG;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_SIG: begin
            if (off_ff == OFF_SIG_LAST) begin
               state_in = S_SIGEND;
            end
         end
         S_SIGEND: begin
            if (!match_ff) begin
               state_in = S_CHECK;
            end else if (c_cut) begin
               state_in = S_RESULT;
            end else if (c_wait17) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_TIFF;
            end
         end
         S_TIFF: begin
            if (off_ff == OFF_TIFF_LAST) begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath updates and result capture.
   always_comb begin
      count_in   = count_ff;
      idx_in     = idx_ff;
      pos_in     = pos_ff;
      fin_in     = fin_ff;
      mark_lo_in = mark_lo_ff;
      seg_in     = seg_ff;
      match_in   = match_ff;
      tiff_we    = 1'b0;
      emit_en    = 1'b0;
      emit_code  = ST_EXIF_FOUND;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               count_in = cnt_base;
               pos_in   = pos_base;
               fin_in   = fin_base;
               if (take_live) begin
                  idx_in   = cnt_base;
                  count_in = cnt_base + POS_BITS'(1);
                  if (first_bad || second_bad) begin
                     emit_en   = 1'b1;
                     emit_code = ST_NOT_JPEG;
                  end
               end
            end
         end
         S_CHECK: begin
            if (c_end) begin
               emit_en   = 1'b1;
               emit_code = ST_NO_EXIF;
            end else if (c_trunc) begin
               emit_en   = 1'b1;
               emit_code = ST_TRUNCATED;
            end
         end
         S_MARK: begin
            if (!c_ff) begin
               pos_in = pos_ff + POS_BITS'(1);
            end
         end
         S_HEAD: begin
            if (off_ff == OFF_MARK_LO) begin
               mark_lo_in = rd_byte;
            end else if (off_ff == OFF_LEN_HI) begin
               seg_in = {rd_byte, seg_ff[7:0]};
            end else begin
               seg_in = {seg_ff[15:8], rd_byte};
            end
         end
         S_SEGCHK: begin
            if (c_overrun) begin
               emit_en   = 1'b1;
               emit_code = ST_SEG_OVERRUN;
            end else if (c_app1) begin
               match_in = 1'b1;
            end else begin
               pos_in = skip_x[POS_BITS-1:0];
            end
         end
         S_SIG: begin
            match_in = match_ff &
                       (rd_byte == exif_sig_byte(3'(off_ff - OFF_SIG_FIRST)));
         end
         S_SIGEND: begin
            if (!match_ff) begin
               pos_in = skip_x[POS_BITS-1:0];
            end else if (c_cut) begin
               emit_en   = 1'b1;
               emit_code = ST_TIFF_CUT;
            end
         end
         S_TIFF: begin
            tiff_we = 1'b1;
         end
         S_FINAL: begin
            emit_en   = 1'b1;
            emit_code = c_ifd_bad ? ST_IFD_BAD : ST_EXIF_FOUND;
         end
         default: begin
         end
      endcase
      if (emit_en) begin
         fin_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
         pos_ff   <= POS_BITS'(2);
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         pos_ff   <= pos_in;
         fin_ff   <= fin_in;
      end
   end

   // Scan working registers.
   always_ff @(posedge clock) begin
      off_ff     <= rd_off;
      hit_ff     <= rd_hit;
      mark_lo_ff <= mark_lo_in;
      seg_ff     <= seg_in;
      match_ff   <= match_in;
   end

   // TIFF header bytes, filled in arrival order.
   always_ff @(posedge clock) begin
      if (tiff_we) begin
         tiff_ff[3'(off_ff - OFF_TIFF)] <= rd_byte;
      end
   end

   // Result register; all fields but the status are zero on a failure.
   always_ff @(posedge clock) begin
      if (emit_en) begin
         status_ff <= emit_code;
         if (emit_code == ST_EXIF_FOUND) begin
            le_ff     <= order_le;
            tstart_ff <= tstart_x[31:0];
            ifd_ff    <= ifd_val;
            seglen_ff <= seg_ff;
         end else begin
            le_ff     <= 1'b0;
            tstart_ff <= '0;
            ifd_ff    <= '0;
            seglen_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = (state_ff == S_RESULT);
   assign rsp_tdata  = {4'b0000, seglen_ff, ifd_ff, tstart_ff, le_ff, status_ff};

endmodule

>>> design/jesl_ram.sv
// ----------------------------------------------------------------------------
// jesl_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module jesl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/jesl_checker.sv
// ----------------------------------------------------------------------------
// jesl_checker: port-level checks of the Exif segment locator
// Watches the request and response channels of the top level and flags
// response contents or timing that the scan can never produce.
// ----------------------------------------------------------------------------
module jesl_checker
   import jesl_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   // A response that is not taken holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // No new byte request is taken while a response is pending.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request accepted while a response is pending");

   // Failure responses carry only the status code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] != ST_EXIF_FOUND) |-> rsp_tdata[87:3] == '0)
      else $error("failure response carries nonzero fields");

   // A found Exif segment has its first IFD inside the segment.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] == ST_EXIF_FOUND) |->
         ({2'b00, rsp_tdata[67:36]} + 34'd10) <= {18'd0, rsp_tdata[83:68]})
      else $error("IFD offset outside the Exif segment");

   // The status code is never the unused value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] != 3'd7)
      else $error("unknown status code");

endmodule

bind jpeg_exif_segment_locator_core jesl_checker u_jesl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/sv/jpeg_exif_segment_locator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_exif_segment_locator_core_tb: self-checking bench for the Exif locator
// Streams short JPEG-like files into the core one byte per request. Each byte
// is also fed to a behavioral tracker that predicts the answer, if any, per file.
// Answers from the core are compared field by field with the predicted ones.
// Both sides stall at random, and the file length register changes between
// files while the core is idle.
// ----------------------------------------------------------------------------
module jpeg_exif_segment_locator_core_tb;
   import jesl_pkg::*;

   localparam int              CLK_HALF     = 6;
   localparam int              PAUSE_CYCLES = 64;
   localparam int              STALL_LIMIT  = 2000;
   localparam int              ITEM_TARGET  = 1800;
   localparam longint unsigned POS_MASK     = 64'hFFFF_FFFF;
   localparam logic [47:0]     EXIF_TAG     = 48'h4578_6966_0000;

   // One answer of the core, in the order of the response fields.
   typedef struct packed {
      status_type  status;
      logic        little;
      logic [31:0] tiff_pos;
      logic [31:0] ifd_pos;
      logic [15:0] seg_len;
   } exif_answer_type;

   // Behavioral tracker: follows the scan of the current file and keeps the
   // answers that the core still owes.
   class exif_scan_tracker;
      exif_answer_type pending_answers[$];
      int unsigned     failures;
      logic [7:0]      history[WIN_DEPTH];
      longint unsigned bytes_seen;
      longint unsigned scan_pos;
      longint unsigned length_reg;
      bit              done;

      function new();
         failures   = 0;
         length_reg = 0;
         restart();
      endfunction

      function void restart();
         foreach (history[i]) history[i] = 8'h00;
         bytes_seen = 0;
         scan_pos   = 2;
         done       = 0;
      endfunction

      function void set_length(logic [31:0] val);
         length_reg = val;
      endfunction

      // Byte at a file position, or zero when it has left the history.
      function logic [7:0] byte_at(longint unsigned pos);
         longint unsigned age;
         if (pos >= bytes_seen) return 8'h00;
         age = bytes_seen - 1 - pos;
         if (age >= WIN_DEPTH) return 8'h00;
         return history[age];
      endfunction

      function bit close_scan(inout exif_answer_type ans, input status_type st);
         ans.status = st;
         done       = 1;
         return 1;
      endfunction

      // Advances the scan by one byte; returns 1 when the file is answered.
      function bit scan_byte(input logic [7:0] val, input logic flag,
                             output exif_answer_type ans);
         longint unsigned idx, p, t, lf, ifd;
         logic [15:0]     marker, seg, order;
         bit              match;
         ans = '0;
         if (flag) restart();
         if (done) return 0;
         for (int i = WIN_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
         history[0] = val;
         idx        = bytes_seen;
         bytes_seen = (bytes_seen + 1) & POS_MASK;
         lf         = length_reg;

         // Start-of-image check on the first two bytes.
         if (idx == 0) begin
            if (lf < 2 || val != MARKER_PREFIX) return close_scan(ans, ST_NOT_JPEG);
            return 0;
         end
         if (idx == 1 && val != SOI_SECOND) return close_scan(ans, ST_NOT_JPEG);

         // Walk scan positions as far as the received bytes allow.
         forever begin
            p = scan_pos;
            if (p >= lf) return close_scan(ans, ST_NO_EXIF);
            if (p + 4 > lf) return close_scan(ans, ST_TRUNCATED);
            if (p > idx) return 0;
            if (byte_at(p) != MARKER_PREFIX) begin
               scan_pos = (p + 1) & POS_MASK;
               continue;
            end
            if (p + 3 > idx) return 0;
            marker = {byte_at(p), byte_at(p + 1)};
            seg    = {byte_at(p + 2), byte_at(p + 3)};
            if (p + 2 + seg > lf) return close_scan(ans, ST_SEG_OVERRUN);
            if (marker == {MARKER_PREFIX, APP1_CODE} && p + 10 <= lf) begin
               if (p + 9 > idx) return 0;
               match = 1;
               for (int k = 0; k < 6; k++) begin
                  if (byte_at(p + 4 + k) != EXIF_TAG[47 - 8*k -: 8]) match = 0;
               end
               if (match) begin
                  t = p + 10;
                  if (p + 18 > lf) return close_scan(ans, ST_TIFF_CUT);
                  if (p + 17 > idx) return 0;
                  order = {byte_at(t), byte_at(t + 1)};
                  if (order == ORDER_INTEL) begin
                     ifd = {byte_at(t + 7), byte_at(t + 6), byte_at(t + 5), byte_at(t + 4)};
                  end else begin
                     ifd = {byte_at(t + 4), byte_at(t + 5), byte_at(t + 6), byte_at(t + 7)};
                  end
                  if (10 + ifd > seg) return close_scan(ans, ST_IFD_BAD);
                  ans.little   = (order == ORDER_INTEL);
                  ans.tiff_pos = t[31:0];
                  ans.ifd_pos  = ifd[31:0];
                  ans.seg_len  = seg;
                  return close_scan(ans, ST_EXIF_FOUND);
               end
            end
            scan_pos = (p + 2 + seg) & POS_MASK;
         end
      endfunction

      // Called for every accepted byte request.
      function void take_byte(logic [7:0] val, logic flag);
         exif_answer_type ans;
         if (scan_byte(val, flag, ans)) pending_answers.push_back(ans);
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            failures++;
         end
      endfunction

      // Called for every accepted response.
      function void check_answer(logic [RSP_DATA_BITS-1:0] rsp);
         exif_answer_type want;
         if (pending_answers.size() == 0) begin
            $error("response: none expected, actual 0x%0h", rsp);
            failures++;
            return;
         end
         want = pending_answers.pop_front();
         compare_field("status", want.status, rsp[2:0]);
         compare_field("little_endian", want.little, rsp[3]);
         compare_field("tiff_start", want.tiff_pos, rsp[35:4]);
         compare_field("ifd_offset", want.ifd_pos, rsp[67:36]);
         compare_field("segment_length", want.seg_len, rsp[83:68]);
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [31:0]              csr_data;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [7:0]               req_tdata;   // [7:0] data_byte
   logic                     req_tuser;   // [0] first_byte
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;   // [2:0] status, [3] little_endian,
                                          // [35:4] tiff_start, [67:36] ifd_offset,
                                          // [83:68] segment_length, zero pad

   exif_scan_tracker tracker;
   logic [7:0]       file_q[$];
   int unsigned      bytes_sent;
   int unsigned      idle_cycles;
   bit               watch_on;
   bit               quiet;

   jpeg_exif_segment_locator_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Clock generation.
   initial clock = 1'b0;
   always #(CLK_HALF) clock = ~clock;

   // Writes the file length register.
   task automatic write_length(input logic [31:0] val);
      csr_valid = 1'b1;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      tracker.set_length(val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Sends one byte request after a random gap (none when quiet); leaves valid high.
   task automatic send_byte(input logic [7:0] val, input logic flag);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 12);
      repeat (gap) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = val;
      req_tuser  = flag;
      do @(posedge clock); while (!req_tready);
      tracker.take_byte(val, flag);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Sends the first count bytes of the file buffer.
   task automatic send_file(input int count, input logic start_flag);
      for (int i = 0; i < count; i++) send_byte(file_q[i], (i == 0) ? start_flag : 1'b0);
      req_tvalid = 1'b0;
   endtask

   // Waits until every answer is in and the core has gone quiet.
   task automatic settle();
      while (tracker.pending_answers.size() != 0) @(negedge clock);
      repeat (PAUSE_CYCLES) @(negedge clock);
   endtask

   // Appends a marker segment with mostly short lengths.
   function automatic void push_segment();
      logic [15:0] seg;
      int          pick;
      pick = $urandom_range(0, 19);
      if (pick < 17) seg = 16'($urandom_range(0, 14));
      else if (pick < 19) seg = 16'($urandom_range(15, 40));
      else seg = 16'($urandom_range(0, 65535));
      file_q.push_back(MARKER_PREFIX);
      file_q.push_back(8'($urandom_range(0, 255)));
      file_q.push_back(seg[15:8]);
      file_q.push_back(seg[7:0]);
      if (seg > 2 && seg <= 42) repeat (int'(seg) - 2) file_q.push_back(8'($urandom_range(0, 255)));
   endfunction

   // Appends an APP1 segment, mostly with a valid Exif and TIFF header.
   function automatic void push_exif();
      logic [15:0] seg, order;
      logic [31:0] ifd;
      logic [7:0]  val;
      seg = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(16, 36))
                                        : 16'($urandom_range(0, 15));
      file_q.push_back(MARKER_PREFIX);
      file_q.push_back(APP1_CODE);
      file_q.push_back(seg[15:8]);
      file_q.push_back(seg[7:0]);
      for (int k = 0; k < 6; k++) begin
         val = EXIF_TAG[47 - 8*k -: 8];
         if ($urandom_range(0, 15) == 0) val ^= 8'($urandom_range(1, 255));
         file_q.push_back(val);
      end
      case ($urandom_range(0, 9))
         0:       order = 16'($urandom_range(0, 65535));
         1, 2, 3, 4, 5: order = ORDER_INTEL;
         default: order = 16'h4D4D;
      endcase
      file_q.push_back(order[15:8]);
      file_q.push_back(order[7:0]);
      file_q.push_back(8'($urandom_range(0, 255)));
      file_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) != 0 && seg >= 10) ifd = $urandom_range(0, int'(seg) - 9);
      else ifd = $urandom;
      if (order == ORDER_INTEL) begin
         for (int k = 0; k < 4; k++) file_q.push_back(ifd[8*k +: 8]);
      end else begin
         for (int k = 3; k >= 0; k--) file_q.push_back(ifd[8*k +: 8]);
      end
      if (seg > 16) repeat (int'(seg) - 16) file_q.push_back(8'($urandom_range(0, 255)));
   endfunction

   // Builds one random file, sets its length and streams it.
   task automatic random_file();
      int          nseg, exif_slot, count, size;
      bit          has_exif, cut_short;
      logic [31:0] len;
      quiet = ($urandom_range(0, 3) == 0);
      file_q.delete();
      if ($urandom_range(0, 99) < 8) begin
         // Noise, sometimes behind a valid start marker.
         repeat ($urandom_range(1, 12)) file_q.push_back(8'($urandom_range(0, 255)));
         if (file_q.size() >= 2 && $urandom_range(0, 1) == 1) begin
            file_q[0] = MARKER_PREFIX;
            file_q[1] = SOI_SECOND;
         end
      end else begin
         file_q.push_back(MARKER_PREFIX);
         file_q.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : SOI_SECOND);
         nseg      = $urandom_range(0, 3);
         exif_slot = $urandom_range(0, nseg);
         has_exif  = ($urandom_range(0, 9) < 8);
         for (int s = 0; s <= nseg; s++) begin
            if ($urandom_range(0, 9) < 3) begin
               repeat ($urandom_range(1, 3)) file_q.push_back(8'($urandom_range(0, 254)));
            end
            if (has_exif && s == exif_slot) push_exif();
            else if (s < nseg) push_segment();
         end
         if ($urandom_range(0, 9) < 3) begin
            repeat ($urandom_range(1, 6)) file_q.push_back(8'($urandom_range(0, 255)));
         end
      end

      // Length register: mostly the real size, sometimes short, long or huge.
      size = file_q.size();
      case ($urandom_range(0, 19))
         0, 1, 2, 3:     len = 32'(size - $urandom_range(1, (size < 8) ? size : 8));
         4, 5: begin
            repeat ($urandom_range(1, 4)) file_q.push_back(8'($urandom_range(0, 255)));
            len = 32'(file_q.size());
         end
         6:              len = $urandom;
         7:              len = 32'hFFFF_FFFF;
         default:        len = 32'(size);
      endcase

      // Now and then the file is dropped early, or trailing bytes follow it.
      cut_short = ($urandom_range(0, 99) < 8);
      if (cut_short) begin
         count = $urandom_range(1, file_q.size());
      end else begin
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) file_q.push_back(8'($urandom_range(0, 255)));
         end
         count = file_q.size();
      end

      settle();
      write_length(len);
      send_file(count, 1'b1);
   endtask

   // Result side: a random stall before each response is taken.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 12);
         repeat (stall) begin
            rsp_tready = 1'b0;
            @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_answer(rsp_tdata);
   end

   // Watchdog on cycles without any accepted request, response or write.
   always @(posedge clock) begin
      if (watch_on) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end else begin
            idle_cycles = idle_cycles + 1;
         end
      end
   end

   // Main sequence.
   initial begin
      tracker     = new();
      reset       = 1'b1;
      csr_valid   = 1'b0;
      csr_data    = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      quiet       = 1'b0;
      watch_on    = 1'b0;
      idle_cycles = 0;
      bytes_sent  = 0;
      repeat (9) @(negedge clock);
      reset    = 1'b0;
      watch_on = 1'b1;

      // Empty file: a length is set but no byte follows.
      write_length(32'd3);
      // One-byte file; byte 0 counts as the first without the start flag.
      write_length(32'd1);
      file_q = '{8'h00};
      send_file(1, 1'b0);
      // Zero length answers on byte 0; the next byte is dropped.
      settle();
      write_length(32'd0);
      file_q = '{MARKER_PREFIX, 8'h00};
      send_file(2, 1'b1);
      // Scan ends exactly at the end of the file.
      settle();
      write_length(32'd2);
      file_q = '{MARKER_PREFIX, SOI_SECOND};
      send_file(2, 1'b1);
      // Minimal Exif file, Intel order, IFD right at the segment bound.
      settle();
      write_length(32'd22);
      file_q = '{MARKER_PREFIX, SOI_SECOND, MARKER_PREFIX, APP1_CODE, 8'h00, 8'h12,
                 8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00,
                 8'h49, 8'h49, 8'h2A, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF};
      send_file(22, 1'b1);

      // Random files.
      while (bytes_sent < ITEM_TARGET) random_file();

      settle();
      if (tracker.failures == 0 && tracker.pending_answers.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
